@@ rtl/ifws_pkg.sv @@
package ifws_pkg;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned ADDR_W     = $clog2(DEPTH);
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
    localparam int unsigned CAP_W      = 7;
    localparam int unsigned REQ_W      = 3;
    localparam int unsigned CAP_RESET  = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ    = 3'd0,
        REQ_DEQ    = 3'd1,
        REQ_PEEK   = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_SEARCH = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } t_ram_cmd;

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] ptr,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/ifws_if.sv @@
interface ifws_req_if;
    logic                              valid;
    logic                              ready;
    logic [ifws_pkg::REQ_W-1:0]        req_type;
    logic signed [ifws_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface ifws_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic signed [ifws_pkg::DATA_WIDTH-1:0] data_out;
    logic [ifws_pkg::ADDR_W-1:0]            found_index;
    logic [ifws_pkg::CNT_W-1:0]             occupancy;
    logic                                   empty_flag;
    logic                                   full_flag;

    modport source (output valid, output status, output data_out, output found_index,
                    output occupancy, output empty_flag, output full_flag, input ready);
    modport sink   (input valid, input status, input data_out, input found_index,
                    input occupancy, input empty_flag, input full_flag, output ready);
endinterface

@@ rtl/ifws_ram.sv @@
module ifws_ram (
    input  logic                                i_clk,
    input  ifws_pkg::t_ram_cmd                  i_cmd,
    output logic [ifws_pkg::DATA_WIDTH-1:0]     o_rdata
);

    logic [ifws_pkg::DATA_WIDTH-1:0] mem [ifws_pkg::DEPTH];
    logic [ifws_pkg::DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        if (i_cmd.re) begin
            r_rdata <= mem[i_cmd.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/ifws_ctrl.sv @@
module ifws_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ifws_req_if.sink                         i_req,
    ifws_rsp_if.source                       o_rsp,
    input  logic [ifws_pkg::CNT_W-1:0]       i_eff_cap,
    output ifws_pkg::t_ram_cmd               o_ram,
    input  logic [ifws_pkg::DATA_WIDTH-1:0]  i_ram_rdata
);

    ifws_pkg::t_state                  r_state;
    ifws_pkg::t_state                  n_state;
    logic [ifws_pkg::CNT_W-1:0]        r_count;
    logic [ifws_pkg::ADDR_W-1:0]       r_head;
    logic [ifws_pkg::ADDR_W-1:0]       r_idx;
    logic [ifws_pkg::DATA_WIDTH-1:0]   r_key;
    logic                              r_is_deq;
    ifws_pkg::t_status                 r_status;
    logic [ifws_pkg::DATA_WIDTH-1:0]   r_data;
    logic [ifws_pkg::ADDR_W-1:0]       r_found;
    logic                              r_o_valid;
    logic [1:0]                        r_o_status;
    logic [ifws_pkg::DATA_WIDTH-1:0]   r_o_data;
    logic [ifws_pkg::ADDR_W-1:0]       r_o_found;
    logic [ifws_pkg::CNT_W-1:0]        r_o_occ;
    logic                              r_o_empty;
    logic                              r_o_full;

    logic accept;
    logic is_empty;
    logic is_full;
    logic match;
    logic last;
    logic load_out;

    assign accept   = i_req.valid && i_req.ready;
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count >= i_eff_cap);
    assign match    = (i_ram_rdata == r_key);
    assign last     = ((ifws_pkg::CNT_W'(r_idx) + ifws_pkg::CNT_W'(1)) == r_count);
    assign load_out = (r_state == ifws_pkg::S_EMIT) && (!r_o_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ifws_pkg::S_IDLE: begin
                if (accept) begin
                    priority if ((i_req.req_type == ifws_pkg::REQ_DEQ ||
                                  i_req.req_type == ifws_pkg::REQ_PEEK) && !is_empty) begin
                        n_state = ifws_pkg::S_READ;
                    end else if (i_req.req_type == ifws_pkg::REQ_SEARCH && !is_empty) begin
                        n_state = ifws_pkg::S_SEARCH;
                    end else begin
                        n_state = ifws_pkg::S_EMIT;
                    end
                end
            end
            ifws_pkg::S_READ: begin
                n_state = ifws_pkg::S_EMIT;
            end
            ifws_pkg::S_SEARCH: begin
                if (match || last) begin
                    n_state = ifws_pkg::S_EMIT;
                end
            end
            ifws_pkg::S_EMIT: begin
                if (load_out) begin
                    n_state = ifws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ifws_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == ifws_pkg::S_IDLE);
        o_ram.we    = accept && (i_req.req_type == ifws_pkg::REQ_ENQ) && !is_full;
        o_ram.waddr = ifws_pkg::wrap_add(r_head, r_count);
        o_ram.wdata = i_req.value;
        o_ram.re    = 1'b0;
        o_ram.raddr = r_head;
        if (accept && !is_empty && (i_req.req_type == ifws_pkg::REQ_DEQ ||
                                    i_req.req_type == ifws_pkg::REQ_PEEK ||
                                    i_req.req_type == ifws_pkg::REQ_SEARCH)) begin
            o_ram.re = 1'b1;
        end else if (r_state == ifws_pkg::S_SEARCH && !match && !last) begin
            o_ram.re    = 1'b1;
            o_ram.raddr = ifws_pkg::wrap_add(r_head,
                              ifws_pkg::CNT_W'(r_idx) + ifws_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ifws_pkg::S_IDLE;
            r_count   <= '0;
            r_head    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_req.req_type == ifws_pkg::REQ_ENQ && !is_full) begin
                r_count <= r_count + ifws_pkg::CNT_W'(1);
            end else if (accept && i_req.req_type == ifws_pkg::REQ_CLEAR) begin
                r_count <= '0;
                r_head  <= '0;
            end else if (r_state == ifws_pkg::S_READ && r_is_deq) begin
                r_count <= r_count - ifws_pkg::CNT_W'(1);
                r_head  <= ifws_pkg::wrap_add(r_head, ifws_pkg::CNT_W'(1));
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key    <= i_req.value;
            r_is_deq <= (i_req.req_type == ifws_pkg::REQ_DEQ);
            r_idx    <= '0;
            r_data   <= '0;
            r_found  <= '0;
            unique case (i_req.req_type)
                ifws_pkg::REQ_ENQ:    r_status <= is_full ? ifws_pkg::ST_FULL : ifws_pkg::ST_OK;
                ifws_pkg::REQ_DEQ,
                ifws_pkg::REQ_PEEK:   r_status <= is_empty ? ifws_pkg::ST_EMPTY : ifws_pkg::ST_OK;
                ifws_pkg::REQ_SEARCH: r_status <= ifws_pkg::ST_NOTFOUND;
                default:              r_status <= ifws_pkg::ST_OK;
            endcase
        end
        if (r_state == ifws_pkg::S_READ) begin
            r_data <= i_ram_rdata;
        end
        if (r_state == ifws_pkg::S_SEARCH) begin
            if (match) begin
                r_status <= ifws_pkg::ST_OK;
                r_found  <= r_idx;
            end else begin
                r_idx <= r_idx + ifws_pkg::ADDR_W'(1);
            end
        end
        if (load_out) begin
            r_o_status <= r_status;
            r_o_data   <= r_data;
            r_o_found  <= r_found;
            r_o_occ    <= r_count;
            r_o_empty  <= is_empty;
            r_o_full   <= is_full;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.data_out    = r_o_data;
    assign o_rsp.found_index = r_o_found;
    assign o_rsp.occupancy   = r_o_occ;
    assign o_rsp.empty_flag  = r_o_empty;
    assign o_rsp.full_flag   = r_o_full;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ifws_pkg::CNT_W'(ifws_pkg::DEPTH))
        else $error("occupancy exceeds the store depth");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == ifws_pkg::REQ_ENQ && !is_full)
        |=> (r_count == $past(r_count) + ifws_pkg::CNT_W'(1)))
        else $error("accepted enqueue did not advance occupancy");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ifws_pkg::S_SEARCH) |-> (ifws_pkg::CNT_W'(r_idx) < r_count))
        else $error("search walked beyond the stored entries");

    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> (r_state == ifws_pkg::S_IDLE && r_count < i_eff_cap))
        else $error("store written outside an accepted enqueue");
`endif

endmodule

@@ rtl/integer_fifo_with_search.sv @@
// First-in first-out queue of signed 32-bit values in a 64-entry single-port-read store,
// with a settable capacity (values above 64 act as 64), plus a linear search that returns
// the position of the first match counted from the oldest entry. One request is worked at
// a time and each one produces exactly one result transfer. From accepted request to
// result register, when that register is free: enqueue, clear, unused codes and requests
// on an empty queue go straight to the emit state; dequeue and peek first pass a read state
// (one store read), and search stays in a search state comparing entries up to the first
// match or the whole occupancy, since the store's single read port delivers one entry per
// cycle. The next request is taken in the cycle after the result register is loaded, even
// while that result still waits to be taken. No clearing pass follows reset.
module integer_fifo_with_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ifws_req_if.sink                      i_req,
    ifws_rsp_if.source                    o_rsp,
    input  logic                          i_cfg_we,
    input  logic [ifws_pkg::CAP_W-1:0]    i_cfg_wdata
);

    logic [ifws_pkg::CAP_W-1:0]       r_capacity;
    logic [ifws_pkg::CNT_W-1:0]       eff_cap;
    ifws_pkg::t_ram_cmd               ram_cmd;
    logic [ifws_pkg::DATA_WIDTH-1:0]  ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= ifws_pkg::CAP_W'(ifws_pkg::CAP_RESET);
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    assign eff_cap = (int'(r_capacity) > ifws_pkg::DEPTH) ? ifws_pkg::CNT_W'(ifws_pkg::DEPTH)
                                                          : ifws_pkg::CNT_W'(r_capacity);

    ifws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .i_eff_cap   (eff_cap),
        .o_ram       (ram_cmd),
        .i_ram_rdata (ram_rdata)
    );

    ifws_ram u_ram (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

endmodule

@@ verif/integer_fifo_with_search_tb.sv @@
module integer_fifo_with_search_tb;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam logic [ifws_pkg::REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [ifws_pkg::REQ_W-1:0] REQ_SPARE_LAST = 3'd7;
    localparam logic [ifws_pkg::DATA_WIDTH-1:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [ifws_pkg::DATA_WIDTH-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
    localparam logic [ifws_pkg::DATA_WIDTH-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct {
        ifws_pkg::t_status               status;
        logic [ifws_pkg::DATA_WIDTH-1:0] data_out;
        logic [ifws_pkg::ADDR_W-1:0]     found_index;
        logic [ifws_pkg::CNT_W-1:0]      occupancy;
        logic                            empty_flag;
        logic                            full_flag;
    } t_fifo_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ifws_pkg::CAP_W-1:0] i_cfg_wdata;

    ifws_req_if req_if ();
    ifws_rsp_if rsp_if ();

    integer_fifo_with_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [ifws_pkg::DATA_WIDTH-1:0] queue_store [ifws_pkg::DEPTH];
    int unsigned queue_fill;
    int unsigned queue_head;
    int unsigned capacity_reg;
    t_fifo_result pending_results[$];
    int unsigned failures;
    int unsigned cycle_count;
    bit no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned usable_capacity();
        return (capacity_reg > ifws_pkg::DEPTH) ? ifws_pkg::DEPTH : capacity_reg;
    endfunction

    function automatic t_fifo_result apply_request(
            input logic [ifws_pkg::REQ_W-1:0] code,
            input logic [ifws_pkg::DATA_WIDTH-1:0] val);
        t_fifo_result res;
        bit hit;
        res.status = ifws_pkg::ST_OK;
        res.data_out = '0;
        res.found_index = '0;
        hit = 1'b0;
        case (code)
            ifws_pkg::REQ_ENQ: begin
                if (queue_fill >= usable_capacity()) begin
                    res.status = ifws_pkg::ST_FULL;
                end else begin
                    queue_store[(queue_head + queue_fill) % ifws_pkg::DEPTH] = val;
                    queue_fill++;
                end
            end
            ifws_pkg::REQ_DEQ, ifws_pkg::REQ_PEEK: begin
                if (queue_fill == 0) begin
                    res.status = ifws_pkg::ST_EMPTY;
                end else begin
                    res.data_out = queue_store[queue_head];
                    if (code == ifws_pkg::REQ_DEQ) begin
                        queue_head = (queue_head + 1) % ifws_pkg::DEPTH;
                        queue_fill--;
                    end
                end
            end
            ifws_pkg::REQ_CLEAR: begin
                queue_fill = 0;
                queue_head = 0;
            end
            ifws_pkg::REQ_SEARCH: begin
                res.status = ifws_pkg::ST_NOTFOUND;
                for (int unsigned i = 0; i < queue_fill; i++) begin
                    if (!hit && queue_store[(queue_head + i) % ifws_pkg::DEPTH] == val) begin
                        hit = 1'b1;
                        res.status = ifws_pkg::ST_OK;
                        res.found_index = i[ifws_pkg::ADDR_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = queue_fill[ifws_pkg::CNT_W-1:0];
        res.empty_flag = (queue_fill == 0);
        res.full_flag = (queue_fill >= usable_capacity());
        return res;
    endfunction

    function automatic int unsigned idle_length();
        int unsigned roll;
        if (no_idle) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [ifws_pkg::REQ_W-1:0] code,
                                input logic [ifws_pkg::DATA_WIDTH-1:0] val);
        int unsigned gap;
        gap = idle_length();
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= code;
        req_if.value <= val;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.push_back(apply_request(code, val));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [ifws_pkg::CAP_W-1:0] cap);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        capacity_reg = cap;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [ifws_pkg::DATA_WIDTH-1:0] random_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return 32'($urandom_range(0, 15)) - 32'd8;
        end else if (roll < 38) begin
            return (roll[0]) ? MOST_NEGATIVE : MOST_POSITIVE;
        end
        return $urandom;
    endfunction

    function automatic logic [ifws_pkg::DATA_WIDTH-1:0] search_key();
        if (queue_fill > 0 && $urandom_range(0, 99) < 60) begin
            return queue_store[(queue_head + $urandom_range(0, queue_fill - 1))
                               % ifws_pkg::DEPTH];
        end
        return random_value();
    endfunction

    task automatic test_basic_operations();
        send_request(ifws_pkg::REQ_SEARCH, 32'd5);
        send_request(ifws_pkg::REQ_DEQ, '0);
        send_request(ifws_pkg::REQ_PEEK, '0);
        send_request(ifws_pkg::REQ_ENQ, MOST_NEGATIVE);
        send_request(ifws_pkg::REQ_ENQ, MOST_POSITIVE);
        send_request(ifws_pkg::REQ_ENQ, '0);
        send_request(ifws_pkg::REQ_ENQ, MINUS_ONE);
        send_request(ifws_pkg::REQ_ENQ, 32'hAAAA_5555);
        send_request(ifws_pkg::REQ_ENQ, MINUS_ONE);
        send_request(ifws_pkg::REQ_PEEK, '0);
        send_request(ifws_pkg::REQ_SEARCH, MINUS_ONE);
        send_request(ifws_pkg::REQ_SEARCH, MOST_NEGATIVE);
        send_request(ifws_pkg::REQ_SEARCH, 32'h5555_AAAA);
        send_request(ifws_pkg::REQ_DEQ, '0);
        send_request(ifws_pkg::REQ_DEQ, '0);
        send_request(ifws_pkg::REQ_SEARCH, 32'hAAAA_5555);
        for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) begin
            send_request(c[ifws_pkg::REQ_W-1:0], MINUS_ONE);
        end
        send_request(ifws_pkg::REQ_CLEAR, '0);
        send_request(ifws_pkg::REQ_SEARCH, '0);
        send_request(ifws_pkg::REQ_PEEK, '0);
        send_request(ifws_pkg::REQ_ENQ, 32'd7);
        send_request(ifws_pkg::REQ_DEQ, '0);
        send_request(ifws_pkg::REQ_CLEAR, '0);
    endtask

    task automatic test_zero_capacity();
        write_capacity(7'd0);
        send_request(ifws_pkg::REQ_ENQ, 32'd1);
        send_request(ifws_pkg::REQ_SEARCH, 32'd1);
        send_request(ifws_pkg::REQ_PEEK, '0);
        send_request(ifws_pkg::REQ_DEQ, '0);
    endtask

    task automatic test_capacity_saturation();
        write_capacity(7'd127);
        for (int i = 0; i < ifws_pkg::DEPTH; i++) begin
            send_request(ifws_pkg::REQ_ENQ, 32'(i) * 32'h0101_0101);
        end
        send_request(ifws_pkg::REQ_ENQ, MINUS_ONE);
        send_request(ifws_pkg::REQ_SEARCH, 32'(ifws_pkg::DEPTH - 1) * 32'h0101_0101);
        send_request(ifws_pkg::REQ_SEARCH, MINUS_ONE);
        send_request(ifws_pkg::REQ_CLEAR, '0);
    endtask

    task automatic test_capacity_shrink();
        write_capacity(7'd64);
        for (int i = 0; i < 10; i++) begin
            send_request(ifws_pkg::REQ_ENQ, random_value());
        end
        write_capacity(7'd4);
        send_request(ifws_pkg::REQ_ENQ, 32'd99);
        send_request(ifws_pkg::REQ_PEEK, '0);
        repeat (7) send_request(ifws_pkg::REQ_DEQ, '0);
        send_request(ifws_pkg::REQ_ENQ, 32'd99);
        send_request(ifws_pkg::REQ_SEARCH, 32'd99);
        send_request(ifws_pkg::REQ_CLEAR, '0);
    endtask

    task automatic test_random_traffic(input int unsigned items,
                                       input logic [ifws_pkg::CAP_W-1:0] cap,
                                       input int unsigned enq_pct, input bit gapless);
        int unsigned roll;
        write_capacity(cap);
        no_idle = gapless;
        for (int unsigned n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < enq_pct) begin
                send_request(ifws_pkg::REQ_ENQ, random_value());
            end else if (roll < enq_pct + 25) begin
                send_request(ifws_pkg::REQ_DEQ, random_value());
            end else if (roll < enq_pct + 33) begin
                send_request(ifws_pkg::REQ_PEEK, random_value());
            end else if (roll < 97) begin
                send_request(ifws_pkg::REQ_SEARCH, search_key());
            end else if (roll < 99) begin
                send_request(ifws_pkg::REQ_CLEAR, random_value());
            end else begin
                send_request(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
                             random_value());
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_results_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int unsigned stall;
        forever begin
            @(negedge i_clk);
            stall = idle_length();
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
        end
    end

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_fifo_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no request outstanding");
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, rsp_if.status);
                check_field("data_out", $signed(want.data_out), rsp_if.data_out);
                check_field("found_index", want.found_index, rsp_if.found_index);
                check_field("occupancy", want.occupancy, rsp_if.occupancy);
                check_field("empty_flag", want.empty_flag, rsp_if.empty_flag);
                check_field("full_flag", want.full_flag, rsp_if.full_flag);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        failures = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        queue_fill = 0;
        queue_head = 0;
        capacity_reg = ifws_pkg::CAP_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_operations();
        test_zero_capacity();
        test_capacity_saturation();
        test_capacity_shrink();
        test_random_traffic(300, 7'd64, 55, 1'b0);
        test_random_traffic(250, 7'd5, 40, 1'b0);
        test_random_traffic(150, 7'd1, 40, 1'b0);
        test_random_traffic(200, 7'd2, 40, 1'b0);
        test_random_traffic(250, 7'd100, 50, 1'b0);
        test_random_traffic(250, 7'd17, 45, 1'b1);
        test_random_traffic(50, 7'd0, 40, 1'b0);
        test_random_traffic(300, 7'd64, 42, 1'b0);

        wait_results_drained();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
